/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* sv/bcc_pkg.sv */
// Package for the button click classifier: widths, mode and event codes,
// configuration register indexes and reset values. No dependencies.
package bcc_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 16;
    localparam int IDX_WIDTH  = 3;
    localparam int EV_WIDTH   = 3;
    localparam int MODE_WIDTH = 3;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [CFG_WIDTH-1:0]  t_cfg;
    typedef logic [EV_WIDTH-1:0]   t_event;
    typedef logic [MODE_WIDTH-1:0] t_mode;
    typedef logic [IDX_WIDTH-1:0]  t_cfg_idx;

    localparam t_mode M_IDLE     = 3'd0;
    localparam t_mode M_PRESSED  = 3'd1;
    localparam t_mode M_REL_WAIT = 3'd2;
    localparam t_mode M_PRESSED2 = 3'd3;
    localparam t_mode M_REL2     = 3'd4;
    localparam t_mode M_PRESSED3 = 3'd5;

    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_SHORT   = 3'd1;
    localparam t_event EV_LONG    = 3'd2;
    localparam t_event EV_XLONG   = 3'd3;
    localparam t_event EV_DOUBLE  = 3'd4;
    localparam t_event EV_TRIPLE  = 3'd5;
    localparam t_event EV_DLONG   = 3'd6;
    localparam t_event EV_FACTORY = 3'd7;

    localparam t_cfg_idx CFG_DEBOUNCE = 3'd0;
    localparam t_cfg_idx CFG_WINDOW   = 3'd1;
    localparam t_cfg_idx CFG_LONG     = 3'd2;
    localparam t_cfg_idx CFG_XLONG    = 3'd3;
    localparam t_cfg_idx CFG_FACTORY  = 3'd4;

    localparam t_cfg RST_DEBOUNCE = 16'd50;
    localparam t_cfg RST_WINDOW   = 16'd300;
    localparam t_cfg RST_LONG     = 16'd1000;
    localparam t_cfg RST_XLONG    = 16'd3000;
    localparam t_cfg RST_FACTORY  = 16'd10000;

endpackage

/* sv/button_click_classifier.sv */
// Button click classifier: debounce plus click/long-press state machine.
// Depends on bcc_pkg.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------
//  in      | i_in_valid   | o_in_stall   | i_raw_level, i_time_ms
//  out     | o_out_valid  | i_out_stall  | o_click_event, o_is_pressed
//  cfg     | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// One word per cycle while the result is not stalled; each word passes the input register, then the result register.
// The state update sits between the two registers, two subtract-compares deep
// (debounce, then hold or click window).
// Synchronous active-low reset: idle mode, levels released, cfg defaults.
// A stalled result holds; the input register keeps taking words until it
// is full behind the stalled result.
module button_click_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_raw_level,
    input  bcc_pkg::t_time       i_time_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bcc_pkg::t_event      o_click_event,
    output logic                 o_is_pressed,
    input  logic                 i_cfg_we,
    input  bcc_pkg::t_cfg_idx    i_cfg_idx,
    input  bcc_pkg::t_cfg        i_cfg_data
);
    import bcc_pkg::*;

    t_cfg   r_deb, r_win, r_long, r_xlong, r_fact;

    logic   r_in_vld;
    logic   r_in_raw;
    t_time  r_in_time;

    logic   r_out_vld;
    t_event r_out_ev;
    logic   r_out_pressed;

    t_mode  r_mode, n_mode;
    logic   r_prev_raw;
    logic   r_stable, n_stable;
    t_time  r_last_chg, n_last_chg;
    t_time  r_press_stamp, n_press_stamp;
    t_time  r_release_stamp, n_release_stamp;
    logic   r_long_f, n_long_f;
    logic   r_xlong_f, n_xlong_f;
    logic   r_fact_f, n_fact_f;
    t_event n_ev;

    logic   out_take;
    logic   stage_move;
    logic   in_take;
    logic   deb_ok;
    t_time  held;
    t_time  since;

    assign out_take   = !r_out_vld || !i_out_stall;
    assign stage_move = r_in_vld && out_take;
    assign o_in_stall = r_in_vld && !out_take;
    assign in_take    = i_in_valid && !o_in_stall;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb   <= RST_DEBOUNCE;
            r_win   <= RST_WINDOW;
            r_long  <= RST_LONG;
            r_xlong <= RST_XLONG;
            r_fact  <= RST_FACTORY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE: r_deb   <= i_cfg_data;
                CFG_WINDOW:   r_win   <= i_cfg_data;
                CFG_LONG:     r_long  <= i_cfg_data;
                CFG_XLONG:    r_xlong <= i_cfg_data;
                CFG_FACTORY:  r_fact  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_raw  <= i_raw_level;
            r_in_time <= i_time_ms;
        end
    end

    // next state for the word in the input register
    always_comb begin
        n_mode          = r_mode;
        n_stable        = r_stable;
        n_last_chg      = r_last_chg;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_long_f        = r_long_f;
        n_xlong_f       = r_xlong_f;
        n_fact_f        = r_fact_f;
        n_ev            = EV_NONE;

        if (r_in_raw != r_prev_raw) begin
            n_last_chg = r_in_time;
        end
        deb_ok = (r_in_raw == r_prev_raw)
               && ((r_in_time - r_last_chg) > TIME_WIDTH'(r_deb));

        if (deb_ok && (r_in_raw != r_stable)) begin
            n_stable = r_in_raw;
            if (!r_in_raw) begin
                n_press_stamp = r_in_time;
                n_long_f      = 1'b0;
                n_xlong_f     = 1'b0;
                n_fact_f      = 1'b0;
                unique case (r_mode)
                    M_IDLE:     n_mode = M_PRESSED;
                    M_REL_WAIT: n_mode = M_PRESSED2;
                    M_REL2:     n_mode = M_PRESSED3;
                    default:    n_mode = r_mode;
                endcase
            end else begin
                n_release_stamp = r_in_time;
                unique case (r_mode)
                    M_PRESSED:  n_mode = (r_long_f || r_xlong_f) ? M_IDLE : M_REL_WAIT;
                    M_PRESSED2: n_mode = r_long_f ? M_IDLE : M_REL2;
                    M_PRESSED3: begin
                        n_ev   = EV_TRIPLE;
                        n_mode = M_IDLE;
                    end
                    default:    n_mode = M_IDLE;
                endcase
            end
        end

        held  = r_in_time - n_press_stamp;
        since = r_in_time - n_release_stamp;

        if (!n_stable) begin
            priority if (!n_fact_f && (held >= TIME_WIDTH'(r_fact))) begin
                n_fact_f = 1'b1;
                n_ev     = EV_FACTORY;
            end else if (!n_xlong_f && (held >= TIME_WIDTH'(r_xlong))) begin
                n_xlong_f = 1'b1;
                n_ev      = EV_XLONG;
            end else if (!n_long_f && (held >= TIME_WIDTH'(r_long))) begin
                n_long_f = 1'b1;
                n_ev     = (n_mode == M_PRESSED2) ? EV_DLONG : EV_LONG;
            end else begin
            end
        end else if (since > TIME_WIDTH'(r_win)) begin
            if (n_mode == M_REL_WAIT) begin
                n_ev   = EV_SHORT;
                n_mode = M_IDLE;
            end else if (n_mode == M_REL2) begin
                n_ev   = EV_DOUBLE;
                n_mode = M_IDLE;
            end
        end
    end

    // classifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= M_IDLE;
            r_prev_raw      <= 1'b1;
            r_stable        <= 1'b1;
            r_last_chg      <= '0;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_long_f        <= 1'b0;
            r_xlong_f       <= 1'b0;
            r_fact_f        <= 1'b0;
        end else if (stage_move) begin
            r_mode          <= n_mode;
            r_prev_raw      <= r_in_raw;
            r_stable        <= n_stable;
            r_last_chg      <= n_last_chg;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
            r_long_f        <= n_long_f;
            r_xlong_f       <= n_xlong_f;
            r_fact_f        <= n_fact_f;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_take) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move) begin
            r_out_ev      <= n_ev;
            r_out_pressed <= !n_stable;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_click_event = r_out_ev;
    assign o_is_pressed  = r_out_pressed;

endmodule

/* sv/bcc_checker.sv */
// Port-level checks for the button click classifier, bound to the top level.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input bcc_pkg::t_event      o_click_event,
    input logic                 o_is_pressed
);
    import bcc_pkg::*;

    logic hold_ev;
    logic rel_ev;

    assign hold_ev = (o_click_event == EV_LONG) || (o_click_event == EV_XLONG)
                  || (o_click_event == EV_DLONG) || (o_click_event == EV_FACTORY);
    assign rel_ev  = (o_click_event == EV_SHORT) || (o_click_event == EV_DOUBLE)
                  || (o_click_event == EV_TRIPLE);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_click_event) && $stable(o_is_pressed))
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    `ASSERT_CLK(a_hold_pressed, i_clk, i_rst_n, o_out_valid && hold_ev |-> o_is_pressed)
    `ASSERT_CLK(a_rel_released, i_clk, i_rst_n, o_out_valid && rel_ev |-> !o_is_pressed)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
